// File: design/sttm_pkg.sv
// Shared types, codes and helpers of the stream target/terminator matcher.
package sttm_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int LEN_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = 64;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_FOUND   = 2'd0,
    OUT_TERM    = 2'd1,
    OUT_TIMEOUT = 2'd2,
    OUT_RSVD    = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    REG_TARGET_BYTES = 2'd0,
    REG_TARGET_LEN   = 2'd1,
    REG_TERM_BYTES   = 2'd2,
    REG_TERM_LEN     = 2'd3
  } reg_idx_t;

  // Broadcast step controls from the top level to every cell.
  typedef struct packed {
    logic start;     // reload both tokens at position zero
    logic tgt_adv;   // target token moves this cycle
    logic term_adv;  // terminator token moves this cycle
    logic tgt_any;   // some cell saw a target hit
    logic term_any;  // some cell saw a terminator hit
    logic tgt_eq0;   // byte equals first target byte
  } cell_ctl_t;

  // Per-cell compare status back to the top level.
  typedef struct packed {
    logic tgt_eq;
    logic tgt_hit;
    logic tgt_done;
    logic term_hit;
    logic term_done;
  } cell_stat_t;

  // Saturate a programmed length to the pattern depth.
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len,
                                               input logic [LEN_W-1:0] max_len);
    sat_len = (len > max_len) ? max_len : len;
  endfunction

endpackage

// File: design/sttm_cell.sv
// One pattern position: holds the target and terminator tokens for its slot.
module sttm_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sttm_pkg::cell_ctl_t           ctl,
  input  logic [sttm_pkg::BYTE_W-1:0]   data_byte,
  input  logic [sttm_pkg::BYTE_W-1:0]   tgt_byte,
  input  logic [sttm_pkg::BYTE_W-1:0]   term_byte,
  input  logic [sttm_pkg::LEN_W-1:0]    tgt_len,
  input  logic [sttm_pkg::LEN_W-1:0]    term_len,
  input  logic                          prev_tgt_hit,
  input  logic                          prev_term_hit,
  output sttm_pkg::cell_stat_t          stat
);

  localparam logic [sttm_pkg::LEN_W-1:0] POS_NEXT = sttm_pkg::LEN_W'(IDX + 1);
  localparam logic                       IS_HEAD  = (IDX == 0);
  localparam logic                       IS_SECOND = (IDX == 1);

  logic tgt_tok_r, tgt_tok_nxt;
  logic term_tok_r, term_tok_nxt;
  logic tgt_eq, term_eq;
  logic tgt_restart;

  assign tgt_eq  = (data_byte == tgt_byte);
  assign term_eq = (data_byte == term_byte);

  assign stat.tgt_eq    = tgt_eq;
  assign stat.tgt_hit   = tgt_tok_r & tgt_eq;
  assign stat.tgt_done  = tgt_tok_r & tgt_eq & (POS_NEXT >= tgt_len);
  assign stat.term_hit  = term_tok_r & term_eq;
  assign stat.term_done = term_tok_r & term_eq & (POS_NEXT >= term_len);

  // On a target miss, restart at one if the byte opens the target, else at zero.
  assign tgt_restart = (IS_HEAD & ~ctl.tgt_eq0) | (IS_SECOND & ctl.tgt_eq0);

  always_comb begin
    tgt_tok_nxt  = tgt_tok_r;
    term_tok_nxt = term_tok_r;
    if (ctl.start) begin
      tgt_tok_nxt  = IS_HEAD;
      term_tok_nxt = IS_HEAD;
    end else begin
      if (ctl.term_adv) begin
        term_tok_nxt = ctl.term_any ? prev_term_hit : IS_HEAD;
      end
      if (ctl.tgt_adv) begin
        tgt_tok_nxt = ctl.tgt_any ? prev_tgt_hit : tgt_restart;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_tok_r  <= IS_HEAD;
      term_tok_r <= IS_HEAD;
    end else begin
      tgt_tok_r  <= tgt_tok_nxt;
      term_tok_r <= term_tok_nxt;
    end
  end

endmodule

// File: design/stream_target_terminator_matcher.sv
// Top level: searches a byte stream for a target string, stopping on a terminator.
// A result is registered into the output register, or into the skid entry when that is busy.
// Throughput: one input transfer per cycle while the skid entry is empty; the one-hot token
// row in the cells steps on every byte, and a two-entry output buffer keeps input flowing.
// Reset (synchronous, rst_n low): idle, both match positions at zero, all config
// registers zero, output buffer empty.
module stream_target_terminator_matcher #(
  parameter int MAX_PATTERN = sttm_pkg::MAX_PATTERN
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] outcome, [7:2] zero
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int LW = sttm_pkg::LEN_W;
  localparam int BW = sttm_pkg::BYTE_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

  // ---------------------------------------------------------------------------
  // Configuration registers; 64-bit registers sit at 8-byte strides.
  // ---------------------------------------------------------------------------
  logic [sttm_pkg::PAT_W-1:0] target_bytes_r;
  logic [LW-1:0]              target_len_r;
  logic [sttm_pkg::PAT_W-1:0] term_bytes_r;
  logic [LW-1:0]              term_len_r;
  logic                       cfg_wr;
  sttm_pkg::reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = sttm_pkg::reg_idx_t'(cfg_paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_bytes_r <= '0;
      target_len_r   <= '0;
      term_bytes_r   <= '0;
      term_len_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sttm_pkg::REG_TARGET_BYTES: target_bytes_r <= cfg_pwdata;
        sttm_pkg::REG_TARGET_LEN:   target_len_r   <= cfg_pwdata[LW-1:0];
        sttm_pkg::REG_TERM_BYTES:   term_bytes_r   <= cfg_pwdata;
        sttm_pkg::REG_TERM_LEN:     term_len_r     <= cfg_pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sttm_pkg::REG_TARGET_BYTES: cfg_prdata = target_bytes_r;
      sttm_pkg::REG_TARGET_LEN:   cfg_prdata = {{(64-LW){1'b0}}, target_len_r};
      sttm_pkg::REG_TERM_BYTES:   cfg_prdata = term_bytes_r;
      sttm_pkg::REG_TERM_LEN:     cfg_prdata = {{(64-LW){1'b0}}, term_len_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // Lengths above the cell count saturate to it.
  logic [LW-1:0] tgt_len, term_len;
  assign tgt_len  = sttm_pkg::sat_len(target_len_r, MAX_LEN);
  assign term_len = sttm_pkg::sat_len(term_len_r, MAX_LEN);

  // ---------------------------------------------------------------------------
  // Input decode and search control.
  // ---------------------------------------------------------------------------
  logic               searching_r, searching_nxt;
  logic               in_xfer;
  sttm_pkg::cmd_t     cmd;
  logic               is_start, byte_step, is_timeout;
  logic               term_on, tgt_zero;
  logic               term_fin, tgt_fin;
  logic               push;
  sttm_pkg::outcome_t outcome;

  sttm_pkg::cell_ctl_t  ctl;
  sttm_pkg::cell_stat_t stat [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] tgt_hit_v, tgt_done_v, term_hit_v, term_done_v;

  assign in_xfer    = in_tvalid & in_tready;
  assign cmd        = sttm_pkg::cmd_t'(in_tuser);
  assign is_start   = in_xfer & (cmd == sttm_pkg::CMD_START);
  assign byte_step  = in_xfer & (cmd == sttm_pkg::CMD_DATA) & searching_r;
  assign is_timeout = in_xfer & (cmd == sttm_pkg::CMD_TIMEOUT) & searching_r;
  assign term_on    = (term_len != '0);
  assign tgt_zero   = (tgt_len == '0);

  // Terminator check comes first and wins a tie with the target.
  assign term_fin = byte_step & term_on & (|term_done_v);
  assign tgt_fin  = byte_step & ~term_fin & (tgt_zero | (|tgt_done_v));

  assign ctl.start    = is_start;
  assign ctl.term_adv = byte_step & term_on;
  assign ctl.tgt_adv  = byte_step & ~term_fin & ~tgt_zero;
  assign ctl.term_any = |term_hit_v;
  assign ctl.tgt_any  = |tgt_hit_v;
  assign ctl.tgt_eq0  = stat[0].tgt_eq;

  always_comb begin
    searching_nxt = searching_r;
    if (is_start) begin
      searching_nxt = ~tgt_zero;
    end else if (term_fin | tgt_fin | is_timeout) begin
      searching_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      searching_r <= 1'b0;
    end else begin
      searching_r <= searching_nxt;
    end
  end

  assign push = (is_start & tgt_zero) | term_fin | tgt_fin | is_timeout;

  always_comb begin
    priority if (term_fin) begin
      outcome = sttm_pkg::OUT_TERM;
    end else if (is_timeout) begin
      outcome = sttm_pkg::OUT_TIMEOUT;
    end else begin
      outcome = sttm_pkg::OUT_FOUND;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row: each cell owns one pattern slot and hands its hit to the next.
  // ---------------------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
      logic prev_tgt_hit, prev_term_hit;
      if (gi == 0) begin : g_head
        assign prev_tgt_hit  = 1'b0;
        assign prev_term_hit = 1'b0;
      end else begin : g_link
        assign prev_tgt_hit  = tgt_hit_v[gi-1];
        assign prev_term_hit = term_hit_v[gi-1];
      end

      sttm_cell #(
        .IDX (gi)
      ) u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .data_byte     (in_tdata),
        .tgt_byte      (target_bytes_r[BW*gi +: BW]),
        .term_byte     (term_bytes_r[BW*gi +: BW]),
        .tgt_len       (tgt_len),
        .term_len      (term_len),
        .prev_tgt_hit  (prev_tgt_hit),
        .prev_term_hit (prev_term_hit),
        .stat          (stat[gi])
      );

      assign tgt_hit_v[gi]   = stat[gi].tgt_hit;
      assign tgt_done_v[gi]  = stat[gi].tgt_done;
      assign term_hit_v[gi]  = stat[gi].term_hit;
      assign term_done_v[gi] = stat[gi].term_done;
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Output register plus skid entry; input stalls only when both hold results.
  // ---------------------------------------------------------------------------
  logic               out_valid_r, out_valid_nxt;
  sttm_pkg::outcome_t out_data_r, out_data_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  sttm_pkg::outcome_t skid_data_r, skid_data_nxt;
  logic               pop;

  assign in_tready  = ~skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};
  assign pop        = out_valid_r & out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    // Drain: promote the skid entry or empty the output register.
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    // Fill: the output register first, the skid entry when it is busy.
    if (push) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = outcome;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = outcome;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the stream target/terminator matcher.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sttm_pkg::*;

  // Generous ceiling: about 1100 transfers with random idles and stalls, plus register
  // writes and drain pauses, taken many times over.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_TICKS = 4;   // extra clock edges at the end of drain()
  localparam int PHASE_ITEMS  = 103;
  localparam int RAND_PHASES  = 10;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } feed_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic [1:0]  in_tuser = '0;   // [1:0] cmd

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [1:0] outcome, [7:2] zero

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  stream_target_terminator_matcher uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Shadow copy of the programmed registers, updated when a write completes.
  logic [63:0] want_pat = '0;
  logic [3:0]  want_len = '0;
  logic [63:0] stop_pat = '0;
  logic [3:0]  stop_len = '0;

  // Predicted search state.
  logic [3:0]  want_idx = '0;
  logic [3:0]  stop_idx = '0;
  bit          hunting = 1'b0;

  feed_item_t  byte_feed[$];       // transfers waiting for the driver
  outcome_t    due_outcomes[$];    // outcomes predicted but not yet seen

  int fail_count = 0;
  int fed_count = 0;
  int accepted_count = 0;
  int cfg_writes = 0;
  int cycle_count = 0;
  int outcome_tally[4] = '{default: 0};

  // Idle/stall shaping, changed per phase; quiet turns all idling off.
  int  in_idle_pct = 20;
  int  out_stall_pct = 20;
  bit  quiet = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  // Advance the predicted search by one accepted transfer.
  function automatic void advance_search(input cmd_t cmd, input logic [7:0] b);
    logic [3:0] tl;
    logic [3:0] kl;
    tl = (want_len > MAX_PATTERN) ? 4'(MAX_PATTERN) : want_len;
    kl = (stop_len > MAX_PATTERN) ? 4'(MAX_PATTERN) : stop_len;
    if (cmd == CMD_START) begin
      want_idx = '0;
      stop_idx = '0;
      if (tl == 0) begin
        hunting = 1'b0;
        due_outcomes.push_back(OUT_FOUND);
      end else begin
        hunting = 1'b1;
      end
      return;
    end
    // Drop anything while idle, and the unused command always.
    if (!hunting || cmd == CMD_NONE) return;
    if (cmd == CMD_TIMEOUT) begin
      hunting = 1'b0;
      due_outcomes.push_back(OUT_TIMEOUT);
      return;
    end
    // Terminator is checked first, so it wins a tie with the target.
    if (kl != 0) begin
      if (b == stop_pat[8*stop_idx[2:0] +: 8]) begin
        stop_idx = stop_idx + 4'd1;
        if (stop_idx >= kl) begin
          hunting = 1'b0;
          due_outcomes.push_back(OUT_TERM);
          return;
        end
      end else begin
        stop_idx = '0;
      end
    end
    if (tl == 0) begin
      hunting = 1'b0;
      due_outcomes.push_back(OUT_FOUND);
      return;
    end
    if (b == want_pat[8*want_idx[2:0] +: 8]) begin
      want_idx = want_idx + 4'd1;
      if (want_idx >= tl) begin
        hunting = 1'b0;
        due_outcomes.push_back(OUT_FOUND);
      end
    end else begin
      // Naive restart: only the first target byte is reconsidered.
      want_idx = (b == want_pat[7:0]) ? 4'd1 : 4'd0;
    end
  endfunction

  // Input driver: hold a transfer until it is taken, idle in random bursts.
  always @(posedge clk) begin : in_driver
    feed_item_t nxt;
    logic       fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        advance_search(cmd_t'(in_tuser), in_tdata);
        accepted_count++;
      end
      if (!in_tvalid || fire) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (byte_feed.size() != 0 && !quiet &&
                     $urandom_range(99) < in_idle_pct) begin
          in_gap <= $urandom_range(14);
          in_tvalid <= 1'b0;
        end else if (byte_feed.size() != 0) begin
          nxt = byte_feed.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.cmd;
          in_tdata <= nxt.data;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest prediction.
  always @(posedge clk) begin : out_monitor
    outcome_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_outcomes.size() == 0) begin
          $error("outcome: no result expected, actual %0d", out_tdata[1:0]);
          fail_count++;
        end else begin
          want = due_outcomes.pop_front();
          outcome_tally[want]++;
          if (out_tdata[1:0] !== want) begin
            $error("outcome: expected %0d, actual %0d", want, out_tdata[1:0]);
            fail_count++;
          end
          if (out_tdata[7:2] !== 6'd0) begin
            $error("tdata pad: expected 0, actual %0d", out_tdata[7:2]);
            fail_count++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < out_stall_pct) begin
        out_gap <= $urandom_range(14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stream_target_terminator_matcher verification failed");
      $finish;
    end
  end

  task automatic feed(input cmd_t cmd, input logic [7:0] data);
    byte_feed.push_back('{cmd: cmd, data: data});
    fed_count++;
  endtask

  // Push the first n bytes of a pattern as data transfers.
  task automatic feed_run(input logic [63:0] pat, input int n);
    for (int k = 0; k < n && k < MAX_PATTERN; k++) feed(CMD_DATA, pat[8*k +: 8]);
  endtask

  // Setup then access cycle; the register takes the value on the access edge.
  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_TARGET_BYTES: want_pat = val;
      REG_TARGET_LEN:   want_len = val[3:0];
      REG_TERM_BYTES:   stop_pat = val;
      REG_TERM_LEN:     stop_len = val[3:0];
    endcase
    cfg_writes++;
  endtask

  // Wait until every transfer is taken and every result has come back, then settle.
  task automatic drain();
    while (byte_feed.size() != 0 || in_tvalid || due_outcomes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0]  sym[3];
    logic [63:0] pat_a;
    logic [63:0] pat_b;
    int          la;
    int          lb;
    int          phase_end;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle bytes, idle timeouts and the unused command are dropped;
    // a start with an empty target reports found at once.
    feed(CMD_DATA, 8'h55);
    feed(CMD_TIMEOUT, 8'h00);
    feed(CMD_NONE, 8'hFF);
    feed(CMD_START, 8'h00);
    drain();

    cfg_write(REG_TARGET_BYTES, 64'h0000_0000_0043_4241);   // "ABC"
    cfg_write(REG_TARGET_LEN, 64'd3);
    cfg_write(REG_TERM_BYTES, 64'h0000_0000_0000_0A0D);     // CR LF
    cfg_write(REG_TERM_LEN, 64'd2);
    // Byte extremes, a repeated first byte, then a full target.
    feed(CMD_START, 8'hFF);
    feed(CMD_DATA, 8'h00);
    feed(CMD_DATA, 8'hFF);
    feed(CMD_DATA, 8'h41);
    feed(CMD_DATA, 8'h41);
    feed(CMD_DATA, 8'h42);
    feed(CMD_DATA, 8'h43);
    // Restart while searching, then the terminator ends it.
    feed(CMD_START, 8'h00);
    feed(CMD_DATA, 8'h41);
    feed(CMD_START, 8'h00);
    feed(CMD_DATA, 8'h42);
    feed(CMD_DATA, 8'h0D);
    feed(CMD_DATA, 8'h0A);
    // Unused command while searching, then a timeout.
    feed(CMD_START, 8'h00);
    feed(CMD_NONE, 8'h41);
    feed(CMD_TIMEOUT, 8'h00);
    drain();

    // Target and terminator complete on the same byte: terminator wins.
    cfg_write(REG_TARGET_BYTES, 64'h0000_0000_0000_4241);  // "AB"
    cfg_write(REG_TARGET_LEN, 64'd2);
    cfg_write(REG_TERM_BYTES, 64'h0000_0000_0000_0042);    // "B"
    cfg_write(REG_TERM_LEN, 64'd1);
    feed(CMD_START, 8'h00);
    feed(CMD_DATA, 8'h41);
    feed(CMD_DATA, 8'h42);
    // Leave a search armed with the target half matched.
    feed(CMD_START, 8'h00);
    feed(CMD_DATA, 8'h41);
    drain();

    // Empty target seen on a data byte mid-search gives found.
    cfg_write(REG_TARGET_LEN, 64'd0);
    feed(CMD_DATA, 8'h77);
    drain();

    // Random phases: each picks a small alphabet so that target and terminator
    // runs occur often; the search state carries across register changes.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int k = 0; k < 3; k++) sym[k] = 8'($urandom_range(255));
      if (ph == 5) begin
        sym[0] = 8'h00;
        sym[1] = 8'hFF;
      end
      for (int k = 0; k < MAX_PATTERN; k++) begin
        pat_a[8*k +: 8] = sym[$urandom_range(2)];
        pat_b[8*k +: 8] = sym[$urandom_range(2)];
      end
      if (ph == 5) begin
        pat_a = '1;
        pat_b = '0;
      end
      case (ph)
        0: begin
          la = 8;
          lb = 8;
        end
        1: begin
          la = 0;
          lb = 0;
        end
        2: begin
          la = 15;  // saturates to the pattern depth
          lb = $urandom_range(1, 3);
        end
        4: begin
          la = $urandom_range(1, 8);
          lb = 12;
        end
        default: begin
          la = $urandom_range(1, 10);
          lb = $urandom_range(0, 8);
        end
      endcase
      cfg_write(REG_TARGET_BYTES, pat_a);
      cfg_write(REG_TARGET_LEN, 64'(la));
      cfg_write(REG_TERM_BYTES, pat_b);
      cfg_write(REG_TERM_LEN, 64'(lb));

      in_idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 8 : 30);
      out_stall_pct = (ph % 3 == 2) ? 0 : ((ph % 3 == 0) ? 10 : 35);
      quiet = (ph >= RAND_PHASES - 2);

      phase_end = fed_count + PHASE_ITEMS;
      while (fed_count < phase_end) begin
        if ($urandom_range(9) == 0) begin
          // Noise: any command, any byte.
          feed(cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
        end else begin
          if ($urandom_range(3) != 0) feed(CMD_START, 8'($urandom_range(255)));
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(4))
              0: feed_run(want_pat, want_len);
              1: feed_run(stop_pat, $urandom_range(1, 8));
              2: feed_run(want_pat, $urandom_range(1, 8));
              3: feed(CMD_DATA, sym[$urandom_range(2)]);
              default: feed(CMD_DATA, 8'($urandom_range(255)));
            endcase
          end
          if ($urandom_range(5) == 0) feed(CMD_TIMEOUT, 8'($urandom_range(255)));
        end
      end
      drain();
    end

    $display("Ran %0d input transfers across %0d register writes and %0d phases.",
             accepted_count, cfg_writes, RAND_PHASES + 4);
    $display("Checked outcomes: %0d found, %0d terminator, %0d timeout.",
             outcome_tally[OUT_FOUND], outcome_tally[OUT_TERM], outcome_tally[OUT_TIMEOUT]);
    if (fail_count == 0) begin
      $display("stream_target_terminator_matcher verification clean");
    end else begin
      $display("stream_target_terminator_matcher verification failed");
    end
    $finish;
  end

endmodule
